/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rmre_pkg.sv */
// ----------------------------------------------------------------------------
// rmre_pkg
// Shared types and constants of the reference mismatch run encoder.
// ----------------------------------------------------------------------------
package rmre_pkg;

    // run counter saturation point (1..999, three decimal digits at most)
    localparam int MAX_READ_LEN = 255;

    // decimal digits of the saturation point
    localparam int MAX_H = MAX_READ_LEN / 100;
    localparam int MAX_T = (MAX_READ_LEN / 10) % 10;
    localparam int MAX_U = MAX_READ_LEN % 10;

    localparam int CHAR_W = 8;
    localparam int BCD_W  = 4;

    localparam logic [CHAR_W-1:0] DIGIT_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    // fixed result slots of one request, emitted lowest first
    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam logic [SLOT_W-1:0] SLOT_HUND = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_TENS = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_UNIT = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_BASE = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_NL   = 3'd4;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CHAR_W-1:0] ref_char;
        logic [CHAR_W-1:0] read_char;
        logic              read_end;
    } pair_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              item_done;
        logic              record_end;
    } code_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]             slot_vld;
        logic [NUM_SLOTS-1:0][CHAR_W-1:0] slot_chr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

/* rtl/core/rmre_front.sv */
// ----------------------------------------------------------------------------
// rmre_front
// Accepts aligned pairs, tracks the match run and builds output commands.
// ----------------------------------------------------------------------------
module rmre_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pair_valid,
    input  rmre_pkg::pair_t               pair,
    input  rmre_pkg::qstat_t              qstat,
    output logic                          push,
    output rmre_pkg::cmd_t                cmd
);

    logic [rmre_pkg::BCD_W-1:0]  run_h_reg, run_h_next;
    logic [rmre_pkg::BCD_W-1:0]  run_t_reg, run_t_next;
    logic [rmre_pkg::BCD_W-1:0]  run_u_reg, run_u_next;
    logic [rmre_pkg::CHAR_W-1:0] prev_char_reg, prev_char_next;
    logic                        any_emit_reg, any_emit_next;

    logic accept;
    logic mismatch;
    logic run_zero;
    logic run_one;
    logic run_multi;
    logic run_sat;
    logic [rmre_pkg::BCD_W-1:0] inc_h, inc_t, inc_u;

    assign accept    = pair_valid && !qstat.full;
    assign mismatch  = (pair.ref_char != pair.read_char);
    assign run_zero  = (run_h_reg == '0) && (run_t_reg == '0) && (run_u_reg == '0);
    assign run_one   = (run_h_reg == '0) && (run_t_reg == '0)
                       && (run_u_reg == rmre_pkg::BCD_W'(1));
    assign run_multi = !run_zero && !run_one;
    assign run_sat   = (run_h_reg == rmre_pkg::BCD_W'(rmre_pkg::MAX_H))
                       && (run_t_reg == rmre_pkg::BCD_W'(rmre_pkg::MAX_T))
                       && (run_u_reg == rmre_pkg::BCD_W'(rmre_pkg::MAX_U));

    // decimal increment of the run
    always_comb
    begin
        inc_h = run_h_reg;
        inc_t = run_t_reg;
        inc_u = run_u_reg + rmre_pkg::BCD_W'(1);
        if (run_u_reg == rmre_pkg::BCD_W'(9))
        begin
            inc_u = '0;
            inc_t = run_t_reg + rmre_pkg::BCD_W'(1);
            if (run_t_reg == rmre_pkg::BCD_W'(9))
            begin
                inc_t = '0;
                inc_h = run_h_reg + rmre_pkg::BCD_W'(1);
            end
        end
    end

    // command slots
    always_comb
    begin
        cmd = '0;
        cmd.slot_vld[rmre_pkg::SLOT_HUND] = mismatch && run_multi && (run_h_reg != '0);
        cmd.slot_chr[rmre_pkg::SLOT_HUND] = rmre_pkg::DIGIT_ZERO + {4'b0000, run_h_reg};
        cmd.slot_vld[rmre_pkg::SLOT_TENS] = mismatch && run_multi
                                            && ((run_h_reg != '0) || (run_t_reg != '0));
        cmd.slot_chr[rmre_pkg::SLOT_TENS] = rmre_pkg::DIGIT_ZERO + {4'b0000, run_t_reg};
        cmd.slot_vld[rmre_pkg::SLOT_UNIT] = mismatch && !run_zero;
        cmd.slot_chr[rmre_pkg::SLOT_UNIT] = run_one ? prev_char_reg
                                            : rmre_pkg::DIGIT_ZERO + {4'b0000, run_u_reg};
        // mismatching base, or '0' for a read that produced nothing
        cmd.slot_vld[rmre_pkg::SLOT_BASE] = mismatch || (pair.read_end && !any_emit_reg);
        cmd.slot_chr[rmre_pkg::SLOT_BASE] = mismatch ? pair.read_char : rmre_pkg::DIGIT_ZERO;
        cmd.slot_vld[rmre_pkg::SLOT_NL]   = pair.read_end;
        cmd.slot_chr[rmre_pkg::SLOT_NL]   = rmre_pkg::NEWLINE_CHAR;
    end

    assign push = accept && (|cmd.slot_vld);

    always_comb
    begin
        run_h_next     = run_h_reg;
        run_t_next     = run_t_reg;
        run_u_next     = run_u_reg;
        prev_char_next = prev_char_reg;
        any_emit_next  = any_emit_reg;
        if (accept)
        begin
            if (pair.read_end)
            begin
                run_h_next     = '0;
                run_t_next     = '0;
                run_u_next     = '0;
                prev_char_next = '0;
                any_emit_next  = 1'b0;
            end
            else
            begin
                prev_char_next = pair.read_char;
                if (mismatch)
                begin
                    run_h_next    = '0;
                    run_t_next    = '0;
                    run_u_next    = '0;
                    any_emit_next = 1'b1;
                end
                else if (!run_sat)
                begin
                    run_h_next = inc_h;
                    run_t_next = inc_t;
                    run_u_next = inc_u;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_h_reg     <= '0;
            run_t_reg     <= '0;
            run_u_reg     <= '0;
            prev_char_reg <= '0;
            any_emit_reg  <= 1'b0;
        end
        else
        begin
            run_h_reg     <= run_h_next;
            run_t_reg     <= run_t_next;
            run_u_reg     <= run_u_next;
            prev_char_reg <= prev_char_next;
            any_emit_reg  <= any_emit_next;
        end
    end

endmodule

/* rtl/core/rmre_queue.sv */
// ----------------------------------------------------------------------------
// rmre_queue
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module rmre_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rmre_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output rmre_pkg::cmd_t    head_cmd,
    output rmre_pkg::qstat_t  qstat
);

    rmre_pkg::cmd_t entry_reg [rmre_pkg::QUEUE_DEPTH];

    logic [rmre_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rmre_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rmre_pkg::QCNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign qstat.full  = (count_reg == rmre_pkg::QCNT_W'(rmre_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rmre_pkg::QPTR_W'(rmre_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + rmre_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rmre_pkg::QPTR_W'(rmre_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + rmre_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + rmre_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - rmre_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/rmre_back.sv */
// ----------------------------------------------------------------------------
// rmre_back
// Walks the slots of each command and emits one character per cycle unless code_stall holds the output.
// ----------------------------------------------------------------------------
module rmre_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rmre_pkg::cmd_t    head_cmd,
    input  rmre_pkg::qstat_t  qstat,
    output logic              pop,
    output logic              code_valid,
    input  logic              code_stall,
    output rmre_pkg::code_t   code
);

    logic [rmre_pkg::NUM_SLOTS-1:0]             cur_mask_reg, cur_mask_next;
    logic [rmre_pkg::NUM_SLOTS-1:0][rmre_pkg::CHAR_W-1:0] cur_chr_reg, cur_chr_next;
    logic                                       code_valid_reg, code_valid_next;
    rmre_pkg::code_t                            code_reg, code_next;

    logic                           out_free;
    logic                           cur_busy;
    logic                           emit;
    logic [rmre_pkg::SLOT_W-1:0]    sel_idx;
    logic [rmre_pkg::NUM_SLOTS-1:0] sel_bit;
    logic [rmre_pkg::NUM_SLOTS-1:0] rest_mask;

    // lowest pending slot
    always_comb
    begin
        sel_idx = '0;
        for (int i = rmre_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (cur_mask_reg[i])
            begin
                sel_idx = rmre_pkg::SLOT_W'(i);
            end
        end
    end

    assign sel_bit   = rmre_pkg::NUM_SLOTS'(1) << sel_idx;
    assign rest_mask = cur_mask_reg & ~sel_bit;
    assign out_free  = !code_valid_reg || !code_stall;
    assign cur_busy  = |cur_mask_reg;
    assign emit      = cur_busy && out_free;
    assign pop       = !qstat.empty && (!cur_busy || (emit && (rest_mask == '0)));

    always_comb
    begin
        cur_mask_next   = cur_mask_reg;
        cur_chr_next    = cur_chr_reg;
        code_valid_next = code_valid_reg;
        code_next       = code_reg;
        if (pop)
        begin
            cur_mask_next = head_cmd.slot_vld;
            cur_chr_next  = head_cmd.slot_chr;
        end
        else if (emit)
        begin
            cur_mask_next = rest_mask;
        end
        if (out_free)
        begin
            code_valid_next = emit;
        end
        if (emit)
        begin
            code_next.out_char   = cur_chr_reg[sel_idx];
            code_next.item_done  = (rest_mask == '0);
            code_next.record_end = (sel_idx == rmre_pkg::SLOT_NL);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_chr_reg <= cur_chr_next;
        code_reg    <= code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg   <= '0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            cur_mask_reg   <= cur_mask_next;
            code_valid_reg <= code_valid_next;
        end
    end

    assign code_valid = code_valid_reg;
    assign code       = code_reg;

endmodule

/* rtl/core/reference_mismatch_run_encoder.sv */
// ----------------------------------------------------------------------------
// reference_mismatch_run_encoder
// Encodes a read against its reference as run lengths and mismatching bases.
//
//   channel | handshake              | payload          | per request
//   --------+------------------------+------------------+-------------------
//   pair    | pair_valid/pair_stall  | rmre_pkg::pair_t | one aligned pair
//   code    | code_valid/code_stall  | rmre_pkg::code_t | one output char
//
// A pair request is taken every cycle while the command queue (4 entries)
// has room; the front updates the run state in the same cycle.
// The back emits one character per cycle unless code_stall holds the output, so
// a pair yields 0 to 5 output characters; its first character passes through the
// command queue, the back's slot register and the output register.
// pair_stall rises only when the queue is full; code_stall holds the output
// register and backs up through the queue.
// rst_n clears the run state, queue pointers and output valid at once.
// ----------------------------------------------------------------------------
module reference_mismatch_run_encoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    output logic             pair_stall,
    input  rmre_pkg::pair_t  pair,
    output logic             code_valid,
    input  logic             code_stall,
    output rmre_pkg::code_t  code
);

    rmre_pkg::qstat_t qstat;
    rmre_pkg::cmd_t   push_cmd;
    rmre_pkg::cmd_t   head_cmd;
    logic             push;
    logic             pop;

    // front stalls only on a full queue
    assign pair_stall = qstat.full;

    // front: run tracking and slot classification
    rmre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair       (pair),
        .qstat      (qstat),
        .push       (push),
        .cmd        (push_cmd)
    );

    // commands of requests that produce output
    rmre_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    // back: serialize slots into the output register
    rmre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .qstat      (qstat),
        .pop        (pop),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

endmodule

/* rtl/core/rmre_checker.sv */
// ----------------------------------------------------------------------------
// rmre_port_checker
// Port-level checks on the encoder channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmre_port_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    input  logic             pair_stall,
    input  rmre_pkg::pair_t  pair,
    input  logic             code_valid,
    input  logic             code_stall,
    input  rmre_pkg::code_t  code
);

    logic code_held;
    logic pair_held;
    logic nl_seen;
    logic nl_char_ok;

    assign code_held  = code_valid && code_stall;
    assign pair_held  = pair_valid && pair_stall;
    assign nl_seen    = code_valid && code.record_end;
    assign nl_char_ok = (code.out_char == rmre_pkg::NEWLINE_CHAR);

    // stalled output keeps its request
    `ASSERT_NEXT(a_code_hold, clk, rst_n, code_held, code_valid && $stable(code), "code moved")

    // stalled input keeps its request
    `ASSERT_NEXT(a_pair_hold, clk, rst_n, pair_held, pair_valid && $stable(pair), "pair moved")

    // the newline closes the request that caused it
    `ASSERT_IMPL(a_nl_done, clk, rst_n, nl_seen, code.item_done, "record end without item done")

    // record_end only ever marks a newline character
    `ASSERT_IMPL(a_nl_char, clk, rst_n, nl_seen, nl_char_ok, "record end off a newline")

endmodule

bind reference_mismatch_run_encoder rmre_port_checker u_rmre_port_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair       (pair),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code)
);
